FILE: sv/isqrt_pkg.sv
// Shared widths, constants and interface types for the integer square root unit.
// Used by isqrt_core and integer_square_root_unit; depends on nothing.
package isqrt_pkg;

    localparam int RAD_W  = 32;
    localparam int ROOT_W = 16;
    localparam int REM_W  = 16;
    localparam int ITERS  = 16;
    localparam int CNT_W  = 4;
    localparam int DBL_W  = 2;

    localparam logic [RAD_W-1:0] RED_LIMIT  = 32'h3FFF_FFFF;
    localparam logic [RAD_W-1:0] RED_LIMIT2 = 32'hFFFF_FFFC;

    typedef struct packed {
        logic start;
        logic take;
    } t_core_ctl;

    typedef struct packed {
        logic idle;
        logic done;
    } t_core_sts;

endpackage

FILE: sv/isqrt_core.sv
// Digit-serial square root engine: two radicand bits enter the remainder per cycle.
// Depends on isqrt_pkg for widths and the control and status types.
module isqrt_core import isqrt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_core_ctl          i_ctl,
    input  logic [RAD_W-1:0]   i_rad,
    input  logic [DBL_W-1:0]   i_dbl,
    output t_core_sts          o_sts,
    output logic [ROOT_W-1:0]  o_root
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [RAD_W-1:0]  r_rad, n_rad;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [DBL_W-1:0]  r_dbl, n_dbl;

    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              fits;

    assign rem_sh = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign fits   = (rem_sh >= trial);
    assign diff   = rem_sh - trial;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_rad   = r_rad;
        n_rem   = r_rem;
        n_root  = r_root;
        n_dbl   = r_dbl;
        case (r_state)
            S_IDLE: begin
                if (i_ctl.start) begin
                    n_state = S_RUN;
                    n_cnt   = '0;
                    n_rad   = i_rad;
                    n_rem   = '0;
                    n_root  = '0;
                    n_dbl   = i_dbl;
                end
            end
            S_RUN: begin
                n_rad = {r_rad[RAD_W-3:0], 2'b00};
                if (fits) begin
                    n_rem  = diff[REM_W-1:0];
                    n_root = {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem  = rem_sh[REM_W-1:0];
                    n_root = {r_root[ROOT_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ITERS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_ctl.take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt  <= n_cnt;
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_dbl  <= n_dbl;
    end

    always_comb begin
        case (r_dbl)
            2'd0:    o_root = r_root;
            2'd1:    o_root = {r_root[ROOT_W-2:0], 1'b0};
            2'd2:    o_root = {r_root[ROOT_W-3:0], 2'b00};
            default: o_root = {r_root[ROOT_W-4:0], 3'b000};
        endcase
    end

    assign o_sts.idle = (r_state == S_IDLE);
    assign o_sts.done = (r_state == S_DONE);

endmodule

FILE: sv/integer_square_root_unit.sv
// Top level of the integer square root unit: input reduction, engine and output register.
// Depends on isqrt_pkg and isqrt_core.
//
// The unit takes one unsigned 32-bit radicand per transaction and returns one 16-bit
// root. Below 0x3FFFFFFF the root is the exact floor square root. At or above it the
// radicand is shifted right by two (twice from 0xFFFFFFFC up) and the root is doubled
// once per shift, so the result can fall slightly below the true floor root. One
// radicand is worked on at a time: the engine retires two radicand bits per cycle,
// and a new transaction is accepted only after the finished root has moved into the
// output register. The output register holds a finished root while the engine takes
// the next radicand.
module integer_square_root_unit import isqrt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [RAD_W-1:0]  i_radicand,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ROOT_W-1:0] o_root
);

    t_core_ctl         core_ctl;
    t_core_sts         core_sts;
    logic [RAD_W-1:0]  red_rad;
    logic [DBL_W-1:0]  red_dbl;
    logic [ROOT_W-1:0] core_root;
    logic              out_free;
    logic              r_out_valid;
    logic [ROOT_W-1:0] r_out_root;

    always_comb begin
        if (i_radicand >= RED_LIMIT2) begin
            red_rad = {4'b0000, i_radicand[RAD_W-1:4]};
            red_dbl = 2'd2;
        end else if (i_radicand >= RED_LIMIT) begin
            red_rad = {2'b00, i_radicand[RAD_W-1:2]};
            red_dbl = 2'd1;
        end else begin
            red_rad = i_radicand;
            red_dbl = 2'd0;
        end
    end

    assign o_ready        = core_sts.idle;
    assign out_free       = !r_out_valid || i_ready;
    assign core_ctl.start = i_valid && core_sts.idle;
    assign core_ctl.take  = core_sts.done && out_free;

    isqrt_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .i_rad   (red_rad),
        .i_dbl   (red_dbl),
        .o_sts   (core_sts),
        .o_root  (core_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= core_sts.done;
        end
        if (core_ctl.take) begin
            r_out_root <= core_root;
        end
    end

    assign o_valid = r_out_valid;
    assign o_root  = r_out_root;

endmodule
